FILE: design/mot_pkg.sv
package mot_pkg;

   // Default sizes handed to the top-level parameters
   localparam int MAX_DIM_DEF   = 16;
   localparam int ELEM_BITS_DEF = 32;

   // Fixed field widths
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int ORIENT_W  = 3;
   localparam int VALUE_W   = 32;
   localparam int POS_W     = 4;
   localparam int SIZE_W    = 5;

   // Orientation codes whose transform swaps height and width (1, 3, 4, 6)
   localparam logic [7:0] SWAP_CODES = 8'h5A;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b1;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_OP      = 2'd1,
      REQ_READ    = 2'd2,
      REQ_RESTART = 2'd3
   } req_kind_type;

   // D4 orientation codes as folded by rotate and flip transactions
   typedef enum logic [ORIENT_W-1:0] {
      OR_IDENT,
      OR_ROT_CW,
      OR_ROT_HALF,
      OR_ROT_CCW,
      OR_TRANSPOSE,
      OR_MIRROR_COLS,
      OR_ANTI_TRANSPOSE,
      OR_MIRROR_ROWS
   } orient_code_type;

   typedef struct packed {
      req_kind_type              req_type;
      logic signed [VALUE_W-1:0] elem_value;
      logic                      op_is_flip;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [POS_W-1:0]          out_row;
      logic [POS_W-1:0]          out_col;
      logic                      row_end;
      logic                      matrix_end;
      logic [SIZE_W-1:0]         out_height;
      logic [SIZE_W-1:0]         out_width;
   } rsp_payload_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_en;
      logic op_en;
      logic restart_en;
      logic read_en;
      logic rsp_load;
   } ctrl_cmd_type;

endpackage

FILE: design/mot_ctrl.sv
module mot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  mot_pkg::req_kind_type req_type,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   input  logic                  out_full,
   output mot_pkg::ctrl_cmd_type cmd
);
   import mot_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a read waits in ST_FETCH for a free output
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_type == REQ_READ) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!out_full || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  REQ_LOAD:    cmd.load_en    = 1'b1;
                  REQ_OP:      cmd.op_en      = 1'b1;
                  REQ_READ:    cmd.read_en    = 1'b1;
                  REQ_RESTART: cmd.restart_en = 1'b1;
                  default:     cmd            = '0;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.rsp_load = !out_full || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: design/mot_datapath.sv
module mot_datapath #(
   parameter int MAX_DIM   = mot_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mot_pkg::ELEM_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mot_pkg::ctrl_cmd_type                 cmd,
   input  mot_pkg::req_payload_type              req_data,
   input  logic                                  csr_wr_en,
   input  logic [mot_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mot_pkg::CFG_W-1:0]             csr_wr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output mot_pkg::rsp_payload_type              rsp_data,
   output logic                                  out_full
);
   import mot_pkg::*;

   localparam int CAP    = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(CAP);
   localparam int LIDX_W = $clog2(CAP + 1);
   localparam int PTR_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);

   logic [CFG_W-1:0]     num_rows_ff, num_rows_in;
   logic [CFG_W-1:0]     num_cols_ff, num_cols_in;
   logic [ORIENT_W-1:0]  orient_ff, orient_in;
   logic [LIDX_W-1:0]    load_idx_ff, load_idx_in;
   logic [PTR_W-1:0]     read_row_ff, read_row_in;
   logic [PTR_W-1:0]     read_col_ff, read_col_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      meta_ff, meta_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   logic signed [ELEM_BITS-1:0] rd_data_ff;
   logic [ELEM_BITS-1:0] mem [CAP];

   logic [DIM_W-1:0]     rows, cols, h, w;
   logic [PTR_W-1:0]     rl, cl, p, q, r, c;
   logic                 swap, last_col, last_row;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 load_ok;

   // Dimension clamp to 1..MAX_DIM
   always_comb begin
      if (num_rows_ff == '0) begin
         rows = DIM_W'(1);
      end else if (32'(num_rows_ff) > MAX_DIM) begin
         rows = DIM_W'(MAX_DIM);
      end else begin
         rows = DIM_W'(num_rows_ff);
      end
      if (num_cols_ff == '0) begin
         cols = DIM_W'(1);
      end else if (32'(num_cols_ff) > MAX_DIM) begin
         cols = DIM_W'(MAX_DIM);
      end else begin
         cols = DIM_W'(num_cols_ff);
      end
   end

   // Transformed size and current position (stale pointers act as zero)
   always_comb begin
      swap = SWAP_CODES[orient_ff];
      h    = swap ? cols : rows;
      w    = swap ? rows : cols;
      rl   = PTR_W'(rows - DIM_W'(1));
      cl   = PTR_W'(cols - DIM_W'(1));
      p    = (DIM_W'(read_row_ff) >= h) ? '0 : read_row_ff;
      q    = (DIM_W'(read_col_ff) >= w) ? '0 : read_col_ff;
      last_col = (DIM_W'(q) == w - DIM_W'(1));
      last_row = (DIM_W'(p) == h - DIM_W'(1));
   end

   // Source element for each orientation
   always_comb begin
      case (orient_ff)
         OR_IDENT:          begin r = p;      c = q;      end
         OR_ROT_CW:         begin r = q;      c = cl - p; end
         OR_ROT_HALF:       begin r = rl - p; c = cl - q; end
         OR_ROT_CCW:        begin r = rl - q; c = p;      end
         OR_TRANSPOSE:      begin r = q;      c = p;      end
         OR_MIRROR_COLS:    begin r = p;      c = cl - q; end
         OR_ANTI_TRANSPOSE: begin r = rl - q; c = cl - p; end
         default:           begin r = rl - p; c = q;      end
      endcase
      rd_addr = ADDR_W'(r) * ADDR_W'(cols) + ADDR_W'(c);
   end

   // Result metadata captured with the memory read
   always_comb begin
      meta_in            = '0;
      meta_in.out_row    = POS_W'(p);
      meta_in.out_col    = POS_W'(q);
      meta_in.row_end    = last_col;
      meta_in.matrix_end = last_col && last_row;
      meta_in.out_height = SIZE_W'(h);
      meta_in.out_width  = SIZE_W'(w);
   end

   // Control state next values
   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_ROWS: num_rows_in = csr_wr_data;
            CSR_NUM_COLS: num_cols_in = csr_wr_data;
            default:      num_rows_in = num_rows_ff;
         endcase
      end

      orient_in = orient_ff;
      if (cmd.restart_en) begin
         orient_in = '0;
      end else if (cmd.op_en) begin
         if (req_data.op_is_flip) begin
            orient_in = ~orient_ff;
         end else begin
            orient_in = {orient_ff[2], orient_ff[1:0] + 2'd1};
         end
      end

      load_ok     = (32'(load_idx_ff) < CAP);
      load_idx_in = load_idx_ff;
      if (cmd.restart_en) begin
         load_idx_in = '0;
      end else if (cmd.load_en && load_ok) begin
         load_idx_in = load_idx_ff + LIDX_W'(1);
      end

      read_row_in = read_row_ff;
      read_col_in = read_col_ff;
      if (cmd.restart_en) begin
         read_row_in = '0;
         read_col_in = '0;
      end else if (cmd.read_en) begin
         if (!last_col) begin
            read_row_in = p;
            read_col_in = q + PTR_W'(1);
         end else begin
            read_col_in = '0;
            read_row_in = last_row ? '0 : p + PTR_W'(1);
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_data_in           = meta_ff;
      rsp_data_in.out_value = VALUE_W'(rd_data_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= CFG_W'(1);
         num_cols_ff  <= CFG_W'(1);
         orient_ff    <= '0;
         load_idx_ff  <= '0;
         read_row_ff  <= '0;
         read_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         orient_ff    <= orient_in;
         load_idx_ff  <= load_idx_in;
         read_row_ff  <= read_row_in;
         read_col_ff  <= read_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Element store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.load_en && load_ok) begin
         mem[load_idx_ff[ADDR_W-1:0]] <= ELEM_BITS'(req_data.elem_value);
      end
      if (cmd.read_en) begin
         rd_data_ff <= mem[rd_addr];
         meta_ff    <= meta_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_full  = rsp_valid_ff;

endmodule

FILE: design/matrix_orientation_transform_unit.sv
// Load, operation and restart transactions leave the unit idle; req_ready stays high.
// A read transaction first does the registered store read, then moves the element
// into the output register in the fetch state; rsp_valid rises once the element
// is in the output register, where the receiver can take it.
// A read waits in the fetch state while the output register holds an untaken result.
// Synchronous active-high reset clears orientation, load index, read pointers and
// output valid, and sets both dimensions to 1; store contents are not cleared.
module matrix_orientation_transform_unit #(
   parameter int MAX_DIM   = mot_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mot_pkg::ELEM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mot_pkg::req_payload_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mot_pkg::rsp_payload_type      rsp_data,
   input  logic                          csr_wr_en,
   input  logic [mot_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mot_pkg::CFG_W-1:0]     csr_wr_data
);
   import mot_pkg::*;

   ctrl_cmd_type cmd;
   logic         out_full;

   mot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_data.req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .out_full  (out_full),
      .cmd       (cmd)
   );

   mot_datapath #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .out_full    (out_full)
   );

endmodule

FILE: design/mot_checker.sv
module mot_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input mot_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mot_pkg::rsp_payload_type rsp_data
);
   import mot_pkg::*;

   logic read_acc;
   logic other_acc;

   assign read_acc  = req_valid && req_ready && req_data.req_type == REQ_READ;
   assign other_acc = req_valid && req_ready && req_data.req_type != REQ_READ;

   // A new result must follow an accepted read transaction
   a_rise_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(read_acc, 2))
      else $error("result without a read two cycles earlier");

   // Input is held off while a read is being fetched
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      read_acc |=> !req_ready)
      else $error("request accepted during read fetch");

   // Non-read transactions never produce a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (other_acc && !rsp_valid) |=> !rsp_valid)
      else $error("result after a non-read transaction");

   // Last element of the matrix is also last of its row
   a_end_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.matrix_end || rsp_data.row_end))
      else $error("matrix end without row end");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind matrix_orientation_transform_unit mot_checker u_mot_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: dv/matrix_orientation_transform_unit_tb.sv
`timescale 1ns / 1ps

module matrix_orientation_transform_unit_tb;
   import mot_pkg::*;

   localparam int MAX_DIM  = MAX_DIM_DEF;
   localparam int CAPACITY = MAX_DIM * MAX_DIM;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   // Shadow state of the transform
   logic [VALUE_W-1:0]    store_model [CAPACITY];
   orient_code_type       orient = OR_IDENT;
   int                    load_ptr = 0;
   int                    loaded_depth = 0;
   int                    rd_row = 0;
   int                    rd_col = 0;
   logic [CFG_W-1:0]      cfg_rows = 5'd1;
   logic [CFG_W-1:0]      cfg_cols = 5'd1;

   rsp_payload_type       expected_elems [$];
   int                    fail_count = 0;
   int                    sent_count = 0;
   int                    burst_left = 0;
   int                    run_left = 0;
   int                    stall_left = 0;

   matrix_orientation_transform_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Out-of-range dimensions act as the nearest legal size
   function automatic int dim_of(input logic [CFG_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   // A read may only touch store entries that have been loaded at some point
   function automatic bit read_is_safe();
      return dim_of(cfg_rows) * dim_of(cfg_cols) <= loaded_depth;
   endfunction

   // Update the shadow state for one accepted transaction, queue any element
   task automatic model_request(input req_payload_type item);
      int rows, cols, h, w, p, q, r, c;
      logic [1:0] quarter;
      rsp_payload_type elem;
      case (item.req_type)
         REQ_LOAD: begin
            if (load_ptr < CAPACITY) begin
               store_model[load_ptr] = item.elem_value;
               load_ptr++;
               if (load_ptr > loaded_depth) loaded_depth = load_ptr;
            end
         end
         REQ_OP: begin
            if (item.op_is_flip) begin
               orient = orient_code_type'(~orient);
            end else begin
               quarter = orient[1:0] + 2'd1;
               orient = orient_code_type'({orient[2], quarter});
            end
         end
         REQ_RESTART: begin
            orient = OR_IDENT;
            load_ptr = 0;
            rd_row = 0;
            rd_col = 0;
         end
         default: begin
            rows = dim_of(cfg_rows);
            cols = dim_of(cfg_cols);
            if (SWAP_CODES[orient]) begin
               h = cols;
               w = rows;
            end else begin
               h = rows;
               w = cols;
            end
            // stale pointers fall back to zero
            if (rd_row >= h) rd_row = 0;
            if (rd_col >= w) rd_col = 0;
            p = rd_row;
            q = rd_col;
            case (orient)
               OR_IDENT:          begin r = p;            c = q;            end
               OR_ROT_CW:         begin r = q;            c = cols - 1 - p; end
               OR_ROT_HALF:       begin r = rows - 1 - p; c = cols - 1 - q; end
               OR_ROT_CCW:        begin r = rows - 1 - q; c = p;            end
               OR_TRANSPOSE:      begin r = q;            c = p;            end
               OR_MIRROR_COLS:    begin r = p;            c = cols - 1 - q; end
               OR_ANTI_TRANSPOSE: begin r = rows - 1 - q; c = cols - 1 - p; end
               default:           begin r = rows - 1 - p; c = q;            end
            endcase
            elem.out_value  = store_model[(r * cols + c) % CAPACITY];
            elem.out_row    = p[POS_W-1:0];
            elem.out_col    = q[POS_W-1:0];
            elem.row_end    = (q == w - 1);
            elem.matrix_end = (q == w - 1) && (p == h - 1);
            elem.out_height = h[SIZE_W-1:0];
            elem.out_width  = w[SIZE_W-1:0];
            expected_elems.push_back(elem);
            // advance in row-major order of the output, wrap after the last
            if (q + 1 < w) begin
               rd_col = q + 1;
            end else begin
               rd_col = 0;
               rd_row = (p + 1 < h) ? p + 1 : 0;
            end
         end
      endcase
   endtask

   // Send one transaction; the sender idles between bursts of random length
   task automatic send_request(input req_kind_type kind, input logic [VALUE_W-1:0] value,
                               input logic flip);
      req_payload_type item;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      item.req_type   = kind;
      item.elem_value = value;
      item.op_is_flip = flip;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      model_request(item);
      sent_count++;
   endtask

   // Drain: hold the sender off until every element has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_elems.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == CSR_NUM_ROWS) cfg_rows = data;
      else cfg_cols = data;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      wait_idle();
      write_csr(CSR_NUM_ROWS, rows);
      write_csr(CSR_NUM_COLS, cols);
   endtask

   // Reset defaults: a 1x1 matrix, reads wrap on every transaction
   task automatic test_single_element();
      send_request(REQ_LOAD, 32'h7fff_ffff, 1'b1);
      send_request(REQ_READ, 32'h0, 1'b0);
      send_request(REQ_READ, 32'hffff_ffff, 1'b1);
      send_request(REQ_OP, 32'h0, 1'b0);
      send_request(REQ_READ, 32'h0, 1'b0);
      send_request(REQ_RESTART, 32'h0, 1'b0);
   endtask

   // Sign extremes, every operation, a pointer left stale by a rotate
   task automatic test_orientation_ops();
      set_dims(5'd2, 5'd3);
      send_request(REQ_RESTART, 32'h0, 1'b1);
      send_request(REQ_LOAD, 32'h8000_0000, 1'b0);
      send_request(REQ_LOAD, 32'h7fff_ffff, 1'b0);
      send_request(REQ_LOAD, 32'h0000_0000, 1'b0);
      send_request(REQ_LOAD, 32'hffff_ffff, 1'b0);
      send_request(REQ_LOAD, 32'h1234_5678, 1'b0);
      send_request(REQ_LOAD, 32'hedcb_a987, 1'b0);
      repeat (5) send_request(REQ_READ, 32'h0, 1'b0);
      send_request(REQ_OP, 32'h0, 1'b0);
      repeat (2) send_request(REQ_READ, 32'h0, 1'b0);
      send_request(REQ_OP, 32'h0, 1'b1);
      repeat (2) send_request(REQ_READ, 32'h0, 1'b0);
      repeat (3) begin
         send_request(REQ_OP, 32'h0, 1'b0);
         send_request(REQ_READ, 32'h0, 1'b0);
      end
   endtask

   // Dimension registers of zero and above the maximum
   task automatic test_register_limits();
      set_dims(5'd0, 5'd31);
      send_request(REQ_RESTART, 32'h0, 1'b0);
      repeat (16) send_request(REQ_LOAD, $urandom(), 1'b0);
      repeat (3) send_request(REQ_READ, 32'h0, 1'b0);
      send_request(REQ_OP, 32'h0, 1'b0);
      repeat (3) send_request(REQ_READ, 32'h0, 1'b0);
      set_dims(5'd17, 5'd0);
      repeat (2) send_request(REQ_READ, 32'h0, 1'b0);
   endtask

   // Full store, loads past capacity ignored, reads wrap past the last element
   task automatic test_capacity();
      set_dims(5'd16, 5'd16);
      send_request(REQ_RESTART, 32'h0, 1'b0);
      repeat (CAPACITY + 3) send_request(REQ_LOAD, $urandom(), 1'($urandom_range(0, 1)));
      repeat (CAPACITY) send_request(REQ_READ, $urandom(), 1'($urandom_range(0, 1)));
      send_request(REQ_OP, 32'h0, 1'b1);
      repeat (3) send_request(REQ_READ, 32'h0, 1'b0);
   endtask

   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 15))
         0:       return 5'd0;
         1:       return 5'($urandom_range(MAX_DIM + 1, 31));
         2:       return 5'(MAX_DIM);
         default: return 5'($urandom_range(1, 6));
      endcase
   endfunction

   // Phases of: new size, usually restart and a full load, then reads and ops
   task automatic test_random_streams(input int count);
      int target, size, body;
      req_kind_type kind;
      bit fresh;
      target = sent_count + count;
      while (sent_count < target) begin
         set_dims(pick_dim(), pick_dim());
         size = dim_of(cfg_rows) * dim_of(cfg_cols);
         fresh = ($urandom_range(0, 4) != 0);
         if (fresh) send_request(REQ_RESTART, $urandom(), 1'($urandom_range(0, 1)));
         if (fresh || $urandom_range(0, 1) == 0)
            repeat (size) send_request(REQ_LOAD, $urandom(), 1'($urandom_range(0, 1)));
         body = $urandom_range(size, 2 * size + 4);
         repeat (body) begin
            case ($urandom_range(0, 15))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9: kind = REQ_READ;
               10, 11, 12:                   kind = REQ_OP;
               13:                           kind = REQ_LOAD;
               default:                      kind = req_kind_type'($urandom_range(0, 3));
            endcase
            if (kind == REQ_READ && !read_is_safe()) kind = REQ_LOAD;
            send_request(kind, $urandom(), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Receiver stall pattern: ready runs broken by stalls, some long clean runs
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (run_left > 0) begin
         run_left  <= run_left - 1;
         rsp_ready <= 1'b1;
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            run_left   <= $urandom_range(60, 200);
            stall_left <= 0;
         end else begin
            run_left   <= $urandom_range(1, 20);
            stall_left <= $urandom_range(0, 12);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Compare each accepted element with the oldest one predicted
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_elems.size() == 0) begin
            $error("element with no transaction pending: value %0h row %0d col %0d",
                   rsp_data.out_value, rsp_data.out_row, rsp_data.out_col);
            fail_count++;
         end else begin
            want = expected_elems.pop_front();
            check_field("out_value", want.out_value, rsp_data.out_value);
            check_field("out_row", 32'(want.out_row), 32'(rsp_data.out_row));
            check_field("out_col", 32'(want.out_col), 32'(rsp_data.out_col));
            check_field("row_end", 32'(want.row_end), 32'(rsp_data.row_end));
            check_field("matrix_end", 32'(want.matrix_end), 32'(rsp_data.matrix_end));
            check_field("out_height", 32'(want.out_height), 32'(rsp_data.out_height));
            check_field("out_width", 32'(want.out_width), 32'(rsp_data.out_width));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_element();
      test_orientation_ops();
      test_register_limits();
      test_random_streams(1320);
      test_capacity();
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_elems.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (expected_elems.size() != 0)
            $error("%0d predicted elements never arrived", expected_elems.size());
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
design/mot_pkg.sv
design/mot_ctrl.sv
design/mot_datapath.sv
design/matrix_orientation_transform_unit.sv
design/mot_checker.sv
dv/matrix_orientation_transform_unit_tb.sv
